FILE: src/ckr_pkg.sv
package ckr_pkg;

    localparam int SEG_CELLS = 8;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

endpackage

FILE: src/ckr_cell.sv
module ckr_cell #(
    parameter int KEY_BITS = 32,
    parameter int INDEX    = 0
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [5:0]          wr_slot,
    input  logic [KEY_BITS-1:0] wr_key,
    input  logic [KEY_BITS-1:0] wr_link,
    input  logic                search_en,
    input  logic [KEY_BITS-1:0] cur_key,
    input  logic                hit_in,
    input  logic [KEY_BITS-1:0] link_in,
    output logic                hit_out,
    output logic [KEY_BITS-1:0] link_out
);

    logic [KEY_BITS-1:0] stored_key_reg;
    logic [KEY_BITS-1:0] stored_link_reg;
    logic                own_hit;

    always_ff @(posedge clk)
    begin
        if (wr_en && (int'(wr_slot) == INDEX))
        begin
            stored_key_reg  <= wr_key;
            stored_link_reg <= wr_link;
        end
    end

    // lower neighbor has priority
    assign own_hit  = search_en && (stored_key_reg == cur_key);
    assign hit_out  = hit_in | own_hit;
    assign link_out = hit_in ? link_in : stored_link_reg;

endmodule

FILE: src/chain_key_resolver.sv
// write item: busy stays low, no result
// resolve item with no entries in use or zero hops: result in the cycle after start, busy stays low
// otherwise: busy while the chain is searched once per hop, until a miss or the last hop,
// then the result goes through the result register
// the hop time is set by the cell chain, registered after every 8 cells; one item at a time
// rst_n clears control, the strobe and entries_in_use; table contents are undefined until written
module chain_key_resolver #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 32,
    parameter int MAX_HOPS = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               cmd,
    input  logic [5:0]         slot,
    input  logic signed [31:0] entry_key,
    input  logic signed [31:0] entry_next,
    input  logic signed [31:0] query_start,
    input  logic [7:0]         hop_count,
    output logic               done,
    output logic               found,
    output logic signed [31:0] final_key
);

    import ckr_pkg::*;

    localparam int NSEG   = (ENTRIES + SEG_CELLS - 1) / SEG_CELLS;
    localparam int WAIT_W = $clog2(NSEG + 1);
    localparam int HOP_W  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS + 1) : 1;

    state_t              state_reg, state_next;
    logic [6:0]          n_reg;
    logic [KEY_BITS-1:0] cur_reg, cur_next;
    logic [HOP_W-1:0]    hops_reg, hops_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic                done_reg, done_next;
    logic                found_reg, found_next;
    logic signed [31:0]  key_out_reg, key_out_next;

    logic                accept;
    logic                wr_en;
    logic [KEY_BITS-1:0] wr_key;
    logic [KEY_BITS-1:0] wr_link;
    logic [KEY_BITS-1:0] start_key;
    logic [HOP_W-1:0]    hops_sat;

    logic [ENTRIES-1:0]  hit_in_w;
    logic [ENTRIES-1:0]  hit_out_w;
    logic [KEY_BITS-1:0] link_in_w  [ENTRIES];
    logic [KEY_BITS-1:0] link_out_w [ENTRIES];
    logic [NSEG-1:0]     seg_hit_reg;
    logic [KEY_BITS-1:0] seg_link_reg [NSEG];

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign wr_en     = accept && (cmd == CMD_WRITE);
    assign wr_key    = KEY_BITS'($unsigned(entry_key));
    assign wr_link   = KEY_BITS'($unsigned(entry_next));
    assign start_key = KEY_BITS'($unsigned(query_start));
    assign hops_sat  = (int'(hop_count) > MAX_HOPS) ? HOP_W'(MAX_HOPS) : HOP_W'(hop_count);

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign hit_in_w[gi]   = 1'b0;
                assign link_in_w[gi]  = '0;
            end
            else if ((gi % SEG_CELLS) == 0)
            begin : g_seg
                assign hit_in_w[gi]   = seg_hit_reg[gi / SEG_CELLS - 1];
                assign link_in_w[gi]  = seg_link_reg[gi / SEG_CELLS - 1];
            end
            else
            begin : g_link
                assign hit_in_w[gi]   = hit_out_w[gi - 1];
                assign link_in_w[gi]  = link_out_w[gi - 1];
            end

            ckr_cell #(
                .KEY_BITS (KEY_BITS),
                .INDEX    (gi)
            ) u_cell (
                .clk       (clk),
                .wr_en     (wr_en),
                .wr_slot   (slot),
                .wr_key    (wr_key),
                .wr_link   (wr_link),
                .search_en (gi < int'(n_reg)),
                .cur_key   (cur_reg),
                .hit_in    (hit_in_w[gi]),
                .link_in   (link_in_w[gi]),
                .hit_out   (hit_out_w[gi]),
                .link_out  (link_out_w[gi])
            );
        end

        for (gi = 0; gi < NSEG; gi++)
        begin : g_seg_reg
            localparam int LAST = ((gi + 1) * SEG_CELLS < ENTRIES) ?
                                  (gi + 1) * SEG_CELLS - 1 : ENTRIES - 1;
            always_ff @(posedge clk)
            begin
                seg_hit_reg[gi]  <= hit_out_w[LAST];
                seg_link_reg[gi] <= link_out_w[LAST];
            end
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        hops_next    = hops_reg;
        wait_next    = wait_reg;
        done_next    = 1'b0;
        found_next   = found_reg;
        key_out_next = key_out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_RESOLVE))
                begin
                    if (n_reg == 7'd0)
                    begin
                        done_next    = 1'b1;
                        found_next   = 1'b0;
                        key_out_next = '0;
                    end
                    else if (hops_sat == '0)
                    begin
                        done_next    = 1'b1;
                        found_next   = 1'b1;
                        key_out_next = $signed(32'(start_key));
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                        cur_next   = start_key;
                        hops_next  = hops_sat;
                        wait_next  = '0;
                    end
                end
            end
            ST_SEARCH:
            begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == WAIT_W'(NSEG))
                begin
                    wait_next = '0;
                    if (!seg_hit_reg[NSEG-1])
                    begin
                        state_next   = ST_IDLE;
                        done_next    = 1'b1;
                        found_next   = 1'b0;
                        key_out_next = '0;
                    end
                    else if (hops_reg == HOP_W'(1))
                    begin
                        state_next   = ST_IDLE;
                        done_next    = 1'b1;
                        found_next   = 1'b1;
                        key_out_next = $signed(32'(seg_link_reg[NSEG-1]));
                    end
                    else
                    begin
                        cur_next  = seg_link_reg[NSEG-1];
                        hops_next = hops_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            hops_reg  <= '0;
            wait_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hops_reg  <= hops_next;
            wait_reg  <= wait_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                n_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        found_reg   <= found_next;
        key_out_reg <= key_out_next;
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign final_key = key_out_reg;

`ifndef SYNTHESIS
    a_miss_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (final_key == 32'sd0))
        else $error("missed resolve with nonzero key");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (wait_reg <= WAIT_W'(NSEG)))
        else $error("hop wait counter overran");

    a_hops_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (hops_reg != '0))
        else $error("search with no hops left");

    a_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("search ended without result");
`endif

endmodule
